[design/assert_macros.svh]
// assertion helpers for the design files, included by delta_packet_packer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define DPP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// check a property on every clock edge, reset included
`define DPP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/dpp_pkg.sv]
package dpp_pkg;

    localparam int SAMPLES_PER_PACKET = 10;
    localparam int CHANNELS           = 3;
    localparam int SAMPLE_W           = 32;
    localparam int HALF_W             = 16;
    localparam int SLOT_W             = $clog2(SAMPLES_PER_PACKET);
    localparam int CH_W               = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // one bank bit on top of the slot index
    localparam int ADDR_W             = SLOT_W + 1;
    localparam int RAM_DEPTH          = 2 ** ADDR_W;
    localparam int QUEUE_DEPTH        = 2;
    localparam int QPTR_W             = $clog2(QUEUE_DEPTH);

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } wr_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic head;
    } q_status_t;

endpackage

[design/dpp_ram.sv]
module dpp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/dpp_queue.sv]
module dpp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              push_bank,
    input  logic              pop,
    output dpp_pkg::q_status_t status
);

    logic [dpp_pkg::QUEUE_DEPTH-1:0] bank_reg;
    logic [dpp_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [dpp_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [dpp_pkg::QPTR_W:0]        count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            bank_reg[wr_ptr_reg] <= push_bank;
        end
    end

    assign status.full  = (count_reg == (dpp_pkg::QPTR_W + 1)'(dpp_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.head  = bank_reg[rd_ptr_reg];

endmodule

[design/dpp_front.sv]
module dpp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  dpp_pkg::q_status_t q_status,
    output dpp_pkg::wr_t      wr,
    output logic              push,
    output logic              push_bank
);

    logic [dpp_pkg::SLOT_W-1:0] fill_reg;
    logic                       bank_reg;
    logic                       accept;
    logic                       slot_last;

    // a free bank exists whenever the queue is not full
    assign sample_ready = !q_status.full;
    assign accept       = sample_valid && sample_ready;
    assign slot_last    = (fill_reg == dpp_pkg::SLOT_W'(dpp_pkg::SAMPLES_PER_PACKET - 1));

    assign wr.en     = accept;
    assign wr.addr   = {bank_reg, fill_reg};
    assign push      = accept && slot_last;
    assign push_bank = bank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            bank_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (slot_last)
            begin
                fill_reg <= '0;
                bank_reg <= !bank_reg;
            end
            else
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

endmodule

[design/dpp_back.sv]
module dpp_back (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  dpp_pkg::q_status_t                             q_status,
    output logic                                           pop,
    output logic                                           rd_en,
    output logic [dpp_pkg::ADDR_W-1:0]                     rd_addr,
    input  logic [dpp_pkg::CHANNELS-1:0][dpp_pkg::SAMPLE_W-1:0] rd_data,
    output logic                                           half_word_valid,
    input  logic                                           half_word_ready,
    output logic [dpp_pkg::HALF_W-1:0]                     half_word,
    output logic                                           packet_end
);

    // read issue side
    logic [dpp_pkg::CH_W-1:0]   rd_ch_reg;
    logic [dpp_pkg::SLOT_W-1:0] rd_idx_reg;
    // element held in the ram read register
    logic                       b_valid_reg;
    logic [dpp_pkg::CH_W-1:0]   b_ch_reg;
    logic                       b_first_reg;
    logic                       b_last_reg;
    logic                       phase_reg;
    dpp_pkg::sample_t           prev_reg;
    // output register
    logic                       out_valid_reg;
    logic [dpp_pkg::HALF_W-1:0] half_word_reg;
    logic                       packet_end_reg;

    logic             out_free;
    logic             emit;
    logic             first_low;
    logic             b_consume;
    logic             issue;
    logic             rd_last;
    dpp_pkg::sample_t b_data;
    dpp_pkg::sample_t diff;

    assign out_free  = !out_valid_reg || half_word_ready;
    assign emit      = b_valid_reg && out_free;
    // the first sample of a channel goes out as two halfwords
    assign first_low = b_first_reg && !phase_reg;
    assign b_consume = emit && !first_low;
    assign b_data    = rd_data[b_ch_reg];
    assign diff      = b_data - prev_reg;

    assign rd_last = (rd_ch_reg == dpp_pkg::CH_W'(dpp_pkg::CHANNELS - 1))
                  && (rd_idx_reg == dpp_pkg::SLOT_W'(dpp_pkg::SAMPLES_PER_PACKET - 1));
    assign issue   = !q_status.empty && (!b_valid_reg || b_consume);
    assign pop     = issue && rd_last;
    assign rd_en   = issue;
    assign rd_addr = {q_status.head, rd_idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ch_reg     <= '0;
            rd_idx_reg    <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                b_valid_reg <= 1'b1;
                if (rd_idx_reg == dpp_pkg::SLOT_W'(dpp_pkg::SAMPLES_PER_PACKET - 1))
                begin
                    rd_idx_reg <= '0;
                    rd_ch_reg  <= rd_last ? '0 : rd_ch_reg + 1'b1;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end
            else if (b_consume)
            begin
                b_valid_reg <= 1'b0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (half_word_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (first_low)
            begin
                half_word_reg <= b_data[dpp_pkg::HALF_W-1:0];
                phase_reg     <= 1'b1;
            end
            else if (b_first_reg)
            begin
                half_word_reg <= b_data[dpp_pkg::SAMPLE_W-1:dpp_pkg::HALF_W];
            end
            else
            begin
                half_word_reg <= diff[dpp_pkg::HALF_W-1:0];
            end
            packet_end_reg <= b_last_reg && !b_first_reg;
        end
        if (b_consume)
        begin
            prev_reg <= b_data;
        end
        if (issue)
        begin
            b_ch_reg    <= rd_ch_reg;
            b_first_reg <= (rd_idx_reg == '0);
            b_last_reg  <= rd_last;
            phase_reg   <= 1'b0;
        end
    end

    assign half_word_valid = out_valid_reg;
    assign half_word       = half_word_reg;
    assign packet_end      = packet_end_reg;

endmodule

[design/delta_packet_packer.sv]
// delta packet packer
// input channel: sample_valid / sample_ready carry one sample per channel
// (sample_ch0..sample_ch2, signed 32 bit) in each transfer.
// output channel: half_word_valid / half_word_ready carry one 16-bit
// halfword per transfer; packet_end marks the last halfword of a packet.
// every ten input transfers form a packet of 33 halfwords: per channel the
// first sample (low half, then high half) and nine wrapped differences.
// the front writes samples into a two-bank sample ram, one transfer per
// cycle while sample_ready is high, and hands full banks to the back
// through a two-entry queue. the first halfword of a packet passes the
// queue, the ram read register and the output register after the transfer
// that completes it, when the back is idle. the back streams one halfword
// per cycle from its ram read port while half_word_ready is high.
// sample_ready drops only while both banks wait on the back.
// reset clears the fill count, bank pointers, queue and output valid; the
// sample ram is not cleared, every slot is written before it is read.
// a stalled receiver holds the output register, then the ram read stage,
// then the queue fills and the input stalls.
`include "assert_macros.svh"

module delta_packet_packer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  logic signed [31:0]   sample_ch0,
    input  logic signed [31:0]   sample_ch1,
    input  logic signed [31:0]   sample_ch2,
    output logic                 half_word_valid,
    input  logic                 half_word_ready,
    output logic [15:0]          half_word,
    output logic                 packet_end
);

    dpp_pkg::q_status_t q_status;
    dpp_pkg::wr_t       wr;
    logic               push;
    logic               push_bank;
    logic               pop;
    logic               rd_en;
    logic [dpp_pkg::ADDR_W-1:0]                          rd_addr;
    logic [dpp_pkg::CHANNELS-1:0][dpp_pkg::SAMPLE_W-1:0] wr_data;
    logic [dpp_pkg::CHANNELS-1:0][dpp_pkg::SAMPLE_W-1:0] rd_data;

    assign wr_data[0] = sample_ch0;
    assign wr_data[1] = sample_ch1;
    assign wr_data[2] = sample_ch2;

    dpp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .q_status     (q_status),
        .wr           (wr),
        .push         (push),
        .push_bank    (push_bank)
    );

    dpp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_bank (push_bank),
        .pop       (pop),
        .status    (q_status)
    );

    for (genvar c = 0; c < dpp_pkg::CHANNELS; c++)
    begin : g_ram
        dpp_ram #(
            .WIDTH (dpp_pkg::SAMPLE_W),
            .DEPTH (dpp_pkg::RAM_DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr.en),
            .wr_addr (wr.addr),
            .wr_data (wr_data[c]),
            .rd_en   (rd_en),
            .rd_addr (rd_addr),
            .rd_data (rd_data[c])
        );
    end

    dpp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_status        (q_status),
        .pop             (pop),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .half_word_valid (half_word_valid),
        .half_word_ready (half_word_ready),
        .half_word       (half_word),
        .packet_end      (packet_end)
    );

    `DPP_ASSERT(a_no_pop_empty, pop |-> !q_status.empty, "queue popped while empty")
    `DPP_ASSERT(a_no_push_full, push |-> !q_status.full, "queue pushed while full")
    `DPP_ASSERT(a_stall_after_push, $fell(sample_ready) |-> $past(push),
        "input stalled without a completed packet")

endmodule
